// File: rtl/lcd_nine_bit_pixel_framer_macros.svh
// assertion helpers for the nine-bit framer
`ifndef LCD_NINE_BIT_PIXEL_FRAMER_MACROS_SVH
`define LCD_NINE_BIT_PIXEL_FRAMER_MACROS_SVH

// same-cycle implication, cleared while reset is low
`define LCD9_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, cleared while reset is low
`define LCD9_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lcd9_pkg.sv
package lcd9_pkg;

	typedef enum logic [2:0] {
		KIND_CMD     = 3'd0,
		KIND_PARAM   = 3'd1,
		KIND_WINDOW  = 3'd2,
		KIND_FILL    = 3'd3,
		KIND_RAW     = 3'd4,
		KIND_INDEXED = 3'd5,
		KIND_PAL_WR  = 3'd6
	} kind_t;

	localparam logic [7:0] CMD_COLUMN = 8'h2A;
	localparam logic [7:0] CMD_ROW    = 8'h2B;
	localparam logic [7:0] CMD_WRITE  = 8'h2C;

	// packed so that byte_value sits in the lowest bits of the stream word
	typedef struct packed {
		logic [7:0]  index;
		logic [15:0] pixel;
		logic [7:0]  height;
		logic [7:0]  width;
		logic [7:0]  y;
		logic [7:0]  x;
		logic [7:0]  byte_value;
	} item_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] word_byte;
		logic       last;
	} word_t;

	function automatic logic [2:0] word_count(kind_t k);
		logic [2:0] n;
		unique case (k)
			KIND_CMD, KIND_PARAM:               n = 3'd1;
			KIND_WINDOW:                        n = 3'd7;
			KIND_FILL, KIND_RAW, KIND_INDEXED:  n = 3'd2;
			default:                            n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic word_t make_word(kind_t k, logic [2:0] cnt, item_t it,
			logic [15:0] fill, logic [15:0] pal);
		word_t w;
		logic [15:0] colour;
		w = '0;
		colour = '0;
		unique case (k)
			KIND_CMD: begin
				w.is_data = 1'b0;
				w.word_byte = it.byte_value;
				w.last = 1'b1;
			end
			KIND_PARAM: begin
				w.is_data = 1'b1;
				w.word_byte = it.byte_value;
				w.last = 1'b1;
			end
			KIND_WINDOW: begin
				unique case (cnt)
					3'd0: w = '{1'b0, CMD_COLUMN, 1'b0};
					3'd1: w = '{1'b1, it.x + 8'd1, 1'b0};
					3'd2: w = '{1'b1, it.x + it.width, 1'b0};
					3'd3: w = '{1'b0, CMD_ROW, 1'b0};
					3'd4: w = '{1'b1, it.y + 8'd1, 1'b0};
					3'd5: w = '{1'b1, it.y + it.height, 1'b0};
					default: w = '{1'b0, CMD_WRITE, 1'b1};
				endcase
			end
			KIND_FILL, KIND_RAW, KIND_INDEXED: begin
				if (k == KIND_FILL) begin
					colour = fill;
				end else if (k == KIND_RAW) begin
					colour = it.pixel;
				end else begin
					colour = pal;
				end
				w.is_data = 1'b1;
				w.word_byte = (cnt == 3'd0) ? colour[15:8] : colour[7:0];
				w.last = (cnt != 3'd0);
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/lcd9_ram.sv
module lcd9_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/lcd_nine_bit_pixel_framer.sv
// channel   dir  tdata                                         tuser      tlast
// s_*       in   byte_value,x,y,width,height,pixel,index      kind       -
// m_*       out  word_byte                                     is_data    last
// cfg_*     in   fill_color, written when cfg_we is high       -          -
//
// an item is registered on acceptance and, while the output is not stalled, its words leave one per cycle:
// one word for command and parameter, two for pixels, seven for a window
// palette writes and unused kinds leave the stage with no word
// the palette read is issued on acceptance, so its colour is ready when the indexed item reaches the stage
// a new item is taken in the cycle the previous item's last word is loaded
// arst_n clears the valid flags and fill colour; the palette is not cleared
`include "lcd_nine_bit_pixel_framer_macros.svh"

module lcd_nine_bit_pixel_framer #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// byte_value, x, y, width, height, pixel[15:0], index
	input  logic [63:0] s_tdata,
	// kind
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// word_byte
	output logic [7:0]  m_tdata,
	// is_data
	output logic [0:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	import lcd9_pkg::*;

	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

	item_t       item_in;
	kind_t       kind_in;
	logic        idx_ok_in;
	logic        accept;

	logic        valid_s1;
	item_t       item_s1;
	kind_t       kind_s1;
	logic        idx_ok_s1;
	logic [2:0]  cnt_s1;

	logic [15:0] fill_color_q;
	logic [15:0] pal_rdata;
	logic [15:0] pal_colour;

	logic [2:0]  nwords;
	logic        last_word;
	logic        out_free;
	logic        emit;
	logic        done;
	word_t       word;

	logic        m_tvalid_q;
	word_t       out_q;

	assign item_in   = item_t'(s_tdata);
	assign kind_in   = kind_t'(s_tuser);
	assign idx_ok_in = ({1'b0, item_in.index} < PAL_LIMIT);

	assign nwords    = word_count(kind_s1);
	assign last_word = (cnt_s1 == nwords - 3'd1);
	assign out_free  = !m_tvalid_q || m_tready;
	assign emit      = valid_s1 && (nwords != 3'd0) && out_free;
	assign done      = valid_s1 && ((nwords == 3'd0) || (emit && last_word));
	assign s_tready  = !valid_s1 || done;
	assign accept    = s_tvalid && s_tready;

	lcd9_ram #(
		.WIDTH(16),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (accept && (kind_in == KIND_PAL_WR) && idx_ok_in),
		.waddr (item_in.index[PAL_AW-1:0]),
		.wdata (item_in.pixel),
		.re    (accept && (kind_in == KIND_INDEXED)),
		.raddr (item_in.index[PAL_AW-1:0]),
		.rdata (pal_rdata)
	);

	assign pal_colour = idx_ok_s1 ? pal_rdata : 16'h0000;
	assign word = make_word(kind_s1, cnt_s1, item_s1, fill_color_q, pal_colour);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= '0;
		end else if (cfg_we) begin
			fill_color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (accept || done) begin
				cnt_s1 <= '0;
			end else if (emit) begin
				cnt_s1 <= cnt_s1 + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1   <= item_in;
			kind_s1   <= kind_in;
			idx_ok_s1 <= idx_ok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= word;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.word_byte;
	assign m_tuser  = out_q.is_data;
	assign m_tlast  = out_q.last;

	`LCD9_ASSERT_NOW(a_cnt_in_range, clk, arst_n, valid_s1 && (nwords != 3'd0),
		cnt_s1 < nwords, "word counter ran past the item's word count")
	`LCD9_ASSERT_NEXT(a_last_follows_count, clk, arst_n, emit,
		m_tvalid && (m_tlast == $past(last_word)), "tlast does not match the final word")
	`LCD9_ASSERT_NOW(a_pal_write_silent, clk, arst_n,
		valid_s1 && (kind_s1 == KIND_PAL_WR), !emit, "palette write produced a word")
	`LCD9_ASSERT_NEXT(a_busy_holds_item, clk, arst_n, valid_s1 && !done,
		valid_s1 && $stable(kind_s1), "item left the stage before its last word")

endmodule
